FILE: rtl/core/vng_pkg.sv
`default_nettype none
package vng_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int ACC_WIDTH    = 24;
    localparam int NORM_W       = 36;
    localparam int POS_W        = 16;
    localparam int NRM_W        = 16;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TRI   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [9:0]              vertex_a;
        logic [9:0]              vertex_b;
        logic [9:0]              vertex_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } cmd_t;

    typedef struct packed {
        logic [9:0]              vertex_index;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic                    degenerate;
    } rsp_t;

    typedef struct packed {
        logic                    done;
        logic                    zero;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
    } norm_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/vng_cmd_if.sv
`default_nettype none
interface vng_cmd_if import vng_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/vng_rsp_if.sv
`default_nettype none
interface vng_rsp_if import vng_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/vng_norm.sv
`default_nettype none
module vng_norm import vng_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [NORM_W-1:0] vec [3],
    output norm_res_t                     res
);

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_SQRT  = 6'b001000,
        N_DSET  = 6'b010000,
        N_DIV   = 6'b100000
    } nstate_t;

    nstate_t     state_reg, state_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  k_reg, k_next;

    logic [NORM_W-1:0]       m_reg [3];
    logic                    sgn_reg [3];
    logic [59:0]             prod_reg;
    logic [63:0]             sum_reg;
    logic [63:0]             x_reg;
    logic [63:0]             r_reg;
    logic [63:0]             bit_reg;
    logic [32:0]             rem_reg;
    logic [14:0]             low_reg;
    logic [14:0]             q_reg;
    logic signed [NRM_W-1:0] n_reg [3];
    logic                    zero_reg;

    logic        all_zero, any_hi, all_lo;
    logic [63:0] trial;
    logic [44:0] num;
    logic [32:0] rem2;
    logic        q_bit;
    logic [14:0] q_new;
    logic [NORM_W-1:0] mag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = vec[i][NORM_W-1] ? (~vec[i] + 1'b1) : vec[i];
        end
        all_zero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
        any_hi   = (|m_reg[0][NORM_W-1:30]) || (|m_reg[1][NORM_W-1:30])
                   || (|m_reg[2][NORM_W-1:30]);
        all_lo   = !(|m_reg[0][NORM_W-1:29]) && !(|m_reg[1][NORM_W-1:29])
                   && !(|m_reg[2][NORM_W-1:29]);
        trial    = r_reg + bit_reg;
        num      = {1'b0, m_reg[k_reg][29:0], 14'b0} + {14'b0, r_reg[31:1]};
        rem2     = {rem_reg[31:0], low_reg[14]};
        q_bit    = (rem2 >= {1'b0, r_reg[31:0]});
        q_new    = {q_reg[13:0], q_bit};
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    if (all_zero)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = N_SHIFT;
                    end
                end
            end
            N_SHIFT:
            begin
                if (!any_hi && !all_lo)
                begin
                    state_next = N_SQ;
                    cnt_next   = '0;
                end
            end
            N_SQ:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    state_next = N_SQRT;
                    cnt_next   = '0;
                end
            end
            N_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = N_DSET;
                    k_next     = '0;
                end
            end
            N_DSET:
            begin
                state_next = N_DIV;
                cnt_next   = '0;
            end
            N_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd14)
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_next = N_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = N_DSET;
                        k_next     = k_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    zero_reg <= all_zero;
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i]   <= mag[i];
                        sgn_reg[i] <= vec[i][NORM_W-1];
                        if (all_zero)
                        begin
                            n_reg[i] <= '0;
                        end
                    end
                end
            end
            N_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (any_hi)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                    else if (all_lo)
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                end
                sum_reg <= '0;
            end
            N_SQ:
            begin
                if (cnt_reg != 5'd3)
                begin
                    prod_reg <= m_reg[cnt_reg[1:0]][29:0] * m_reg[cnt_reg[1:0]][29:0];
                end
                if (cnt_reg != 5'd0)
                begin
                    sum_reg <= sum_reg + {4'b0, prod_reg};
                end
                x_reg   <= sum_reg + {4'b0, prod_reg};
                r_reg   <= '0;
                bit_reg <= 64'd1 << 62;
            end
            N_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_reg <= x_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DSET:
            begin
                rem_reg <= {3'b0, num[44:15]};
                low_reg <= num[14:0];
                q_reg   <= '0;
            end
            N_DIV:
            begin
                rem_reg <= q_bit ? (rem2 - {1'b0, r_reg[31:0]}) : rem2;
                low_reg <= {low_reg[13:0], 1'b0};
                q_reg   <= q_new;
                if (cnt_reg == 5'd14)
                begin
                    n_reg[k_reg] <= sgn_reg[k_reg] ? -$signed({1'b0, q_new})
                                                   : $signed({1'b0, q_new});
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.done = done_reg;
    assign res.zero = zero_reg;
    assign res.nx   = n_reg[0];
    assign res.ny   = n_reg[1];
    assign res.nz   = n_reg[2];

endmodule
`default_nettype wire

FILE: rtl/core/vertex_normal_generator.sv
// channel  | dir | payload
// cmd      | in  | action, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z
// rsp      | out | vertex_index, normal_x, normal_y, normal_z, degenerate
//
// one request at a time; a load is written as it is accepted and the block stays idle;
// a read or a triangle uses the shared normalize unit; a zero vector, from a zero-sum
// read or a collinear triangle, ends the normalize at once, with no shift, root or divide
// the normalize unit does a shift search one bit a cycle, a 32-step square root
// and three 15-step divisions, one per axis, on a single divider
// no clearing pass after reset: both stores are valid only once loaded
// a finished read result waits in the output register; a next read stalls
// only when its result is ready while the previous one is not yet taken
`default_nettype none
module vertex_normal_generator import vng_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vng_cmd_if.sink    cmd,
    vng_rsp_if.source  rsp
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_TRD    = 10'b0000000010,
        S_TEDGE  = 10'b0000000100,
        S_TMUL   = 10'b0000001000,
        S_NSTART = 10'b0000010000,
        S_NWAIT  = 10'b0000100000,
        S_ARD    = 10'b0001000000,
        S_AWR    = 10'b0010000000,
        S_RCAP   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    localparam logic signed [ACC_WIDTH:0] ACC_LIM =
        (ACC_WIDTH+1)'((1 <<< (ACC_WIDTH - 1)) - 1);

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    logic [1:0]       act_reg;
    logic [9:0]       vidx_reg;
    logic [IDX_W-1:0] corner_reg [3];
    logic signed [POS_W-1:0] p_reg [3][3];
    logic signed [POS_W:0]   e1_reg [3];
    logic signed [POS_W:0]   e2_reg [3];
    logic signed [NORM_W-1:0] vec_reg [3];
    rsp_t             rsp_data_reg;

    logic [3*POS_W-1:0]     pos_mem [MAX_VERTICES];
    logic [3*ACC_WIDTH-1:0] acc_mem [MAX_VERTICES];
    logic [3*POS_W-1:0]     pos_rd_reg;
    logic [3*ACC_WIDTH-1:0] acc_rd_reg;
    logic [IDX_W-1:0]       pos_raddr, acc_raddr, acc_waddr;
    logic [3*ACC_WIDTH-1:0] acc_wdata;
    logic                   pos_we, acc_we, accept, norm_start;

    norm_res_t nres;
    logic signed [NRM_W-1:0] n_face [3];
    logic signed [ACC_WIDTH-1:0] acc_new [3];
    logic signed [2*POS_W+1:0] pa, pb;

    vng_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vec   (vec_reg),
        .res   (nres)
    );

    assign cmd.ready  = (state_reg == S_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign pos_we     = accept && (cmd.data.action == ACT_LOAD);
    assign norm_start = (state_reg == S_NSTART);
    assign n_face[0]  = nres.nx;
    assign n_face[1]  = nres.ny;
    assign n_face[2]  = nres.nz;

    always_comb
    begin
        pos_raddr = corner_reg[cnt_reg];
        acc_raddr = (state_reg == S_IDLE) ? cmd.data.vertex_a[IDX_W-1:0]
                                          : corner_reg[cnt_reg];
        acc_we    = pos_we || (state_reg == S_AWR);
        acc_waddr = pos_we ? cmd.data.vertex_a[IDX_W-1:0] : corner_reg[cnt_reg];
        for (int i = 0; i < 3; i++)
        begin
            logic signed [ACC_WIDTH:0] s;
            s = $signed({acc_rd_reg[i*ACC_WIDTH+ACC_WIDTH-1], acc_rd_reg[i*ACC_WIDTH +: ACC_WIDTH]})
                + ACC_WIDTH'(n_face[i]);
            if (s > ACC_LIM)
            begin
                s = ACC_LIM;
            end
            else if (s < -ACC_LIM)
            begin
                s = -ACC_LIM;
            end
            acc_new[i] = s[ACC_WIDTH-1:0];
        end
        acc_wdata = pos_we ? '0 : {acc_new[2], acc_new[1], acc_new[0]};
        case (cnt_reg)
            2'd0:
            begin
                pa = e1_reg[1] * e2_reg[2];
                pb = e1_reg[2] * e2_reg[1];
            end
            2'd1:
            begin
                pa = e1_reg[2] * e2_reg[0];
                pb = e1_reg[0] * e2_reg[2];
            end
            default:
            begin
                pa = e1_reg[0] * e2_reg[1];
                pb = e1_reg[1] * e2_reg[0];
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    case (cmd.data.action)
                        ACT_TRI:  state_next = S_TRD;
                        ACT_READ: state_next = S_RCAP;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_TRD:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_TEDGE;
                end
            end
            S_TEDGE:
            begin
                state_next = S_TMUL;
                cnt_next   = '0;
            end
            S_TMUL:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    state_next = S_NSTART;
                end
            end
            S_NSTART:
            begin
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                cnt_next = '0;
                if (nres.done)
                begin
                    state_next = (act_reg == ACT_READ) ? S_OUT : S_ARD;
                end
            end
            S_ARD:
            begin
                state_next = S_AWR;
            end
            S_AWR:
            begin
                cnt_next   = cnt_reg + 2'd1;
                state_next = (cnt_reg == 2'd2) ? S_IDLE : S_ARD;
            end
            S_RCAP:
            begin
                state_next = S_NSTART;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[cmd.data.vertex_a[IDX_W-1:0]] <= {cmd.data.pos_z, cmd.data.pos_y,
                                                      cmd.data.pos_x};
        end
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg       <= cmd.data.action;
            vidx_reg      <= cmd.data.vertex_a;
            corner_reg[0] <= cmd.data.vertex_a[IDX_W-1:0];
            corner_reg[1] <= cmd.data.vertex_b[IDX_W-1:0];
            corner_reg[2] <= cmd.data.vertex_c[IDX_W-1:0];
        end
        if ((state_reg == S_TRD) && (cnt_reg != 2'd0))
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_reg[cnt_reg - 2'd1][j] <= pos_rd_reg[j*POS_W +: POS_W];
            end
        end
        if (state_reg == S_TEDGE)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e1_reg[j] <= (POS_W+1)'(p_reg[1][j]) - (POS_W+1)'(p_reg[0][j]);
                e2_reg[j] <= (POS_W+1)'(p_reg[2][j]) - (POS_W+1)'(p_reg[0][j]);
            end
        end
        if (state_reg == S_TMUL)
        begin
            vec_reg[cnt_reg] <= NORM_W'(pa) - NORM_W'(pb);
        end
        if (state_reg == S_RCAP)
        begin
            for (int j = 0; j < 3; j++)
            begin
                vec_reg[j] <= NORM_W'($signed(acc_rd_reg[j*ACC_WIDTH +: ACC_WIDTH]));
            end
        end
        if ((state_reg == S_OUT) && (!out_valid_reg || rsp.ready))
        begin
            rsp_data_reg.vertex_index <= vidx_reg;
            rsp_data_reg.normal_x     <= nres.nx;
            rsp_data_reg.normal_y     <= nres.ny;
            rsp_data_reg.normal_z     <= nres.nz;
            rsp_data_reg.degenerate   <= nres.zero;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = rsp_data_reg;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pos_we |-> (state_reg == S_IDLE))
        else $error("position write outside idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_valid_reg && !rsp.ready) |=> (state_reg == S_OUT))
        else $error("result overwritten while pending");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.degenerate) |->
        ((rsp.data.normal_x == 0) && (rsp.data.normal_y == 0) && (rsp.data.normal_z == 0)))
        else $error("degenerate result with nonzero normal");

    a_norm_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NSTART) |-> !nres.done)
        else $error("normalize unit done before start");

endmodule
`default_nettype wire
